// ===== src/ipv4lpm_pkg.sv =====
// Shared types and constants for the IPv4 longest-prefix-match route table.
`timescale 1ns / 1ps

package ipv4lpm_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int NUM_PORTS       = 4;
    localparam int INDEX_W         = 4;
    localparam int PORT_W          = 2;
    localparam int ADDR_W          = 32;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op                 op;
        logic [INDEX_W-1:0]  entry_index;
        logic [ADDR_W-1:0]   entry_dest;
        logic [ADDR_W-1:0]   entry_mask;
        logic [PORT_W-1:0]   entry_port;
        logic                entry_valid;
        logic [ADDR_W-1:0]   lookup_addr;
    } t_in_item;

    typedef struct packed {
        logic                hit;
        logic [INDEX_W-1:0]  match_index;
        logic [PORT_W-1:0]   match_port;
        logic [ADDR_W-1:0]   match_dest;
    } t_out_item;

    // One stored route, as written to and read from the table.
    typedef struct packed {
        logic [ADDR_W-1:0]   dest;
        logic [ADDR_W-1:0]   mask;
        logic [PORT_W-1:0]   port;
    } t_route;

    // Ports at or above NUM_PORTS saturate to the top port.
    function automatic logic [PORT_W-1:0] sat_port(input logic [PORT_W-1:0] p);
        logic [8:0] wide;
        wide = {{(9-PORT_W){1'b0}}, p};
        if (wide >= 9'(NUM_PORTS)) begin
            return PORT_W'(NUM_PORTS - 1);
        end
        return p;
    endfunction

endpackage

// ===== src/ipv4lpm_table.sv =====
// Route table storage: route memory with registered read, valid flags cleared at reset.
`timescale 1ns / 1ps

module ipv4lpm_table
    import ipv4lpm_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int IDX_W = INDEX_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  t_route           i_wr_route,
    input  logic             i_wr_valid,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_route           o_rd_route,
    output logic             o_rd_valid
);

    t_route             r_mem [DEPTH];
    logic [DEPTH-1:0]   r_valid;
    t_route             r_rd_route;
    logic               r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_route;
        end
        r_rd_route <= r_mem[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= i_wr_valid;
            end
            r_rd_valid <= r_valid[i_rd_idx];
        end
    end

    assign o_rd_route = r_rd_route;
    assign o_rd_valid = r_rd_valid;

endmodule

// ===== src/ipv4_longest_prefix_match.sv =====
// Top level: IPv4 longest-prefix-match route table with a serial compare unit.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes two kinds of item:
//   op = OP_WRITE  loads one route slot; no result. Slots at or above the
//                  table depth are ignored.
//   op = OP_LOOKUP searches the table for the longest matching route and gives
//                  exactly one result item on the output channel.
// Output channel (o_out_valid / i_out_ready / o_out_data) carries hit, slot,
// port and stored destination; on a miss all fields but hit are zero.
// A lookup walks the table one slot per cycle through a single compare unit
// fed by the table's registered read port, over D = min(TABLE_DEPTH, 16)
// slots. The input side is not ready during the walk, nor until the result
// register takes the result, so a new lookup waits for the last one; writes
// go at one per cycle while no lookup is in progress.
// The result register frees the input side at once: a new item may be taken
// while a result waits. If a second lookup finishes while the receiver still
// stalls, it holds its result internally until the register drains.
// Reset (synchronous, active low) clears all valid flags, so every slot misses
// until written; there is no clearing pass.
`timescale 1ns / 1ps

module ipv4_longest_prefix_match
    import ipv4lpm_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // Only the first 16 slots are reachable through the 4-bit write index.
    localparam int EFF_DEPTH = (TABLE_DEPTH < (1 << INDEX_W)) ? TABLE_DEPTH : (1 << INDEX_W);
    localparam int IDX_W     = (EFF_DEPTH > 1) ? $clog2(EFF_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(EFF_DEPTH - 1);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_rd_idx;
    logic               r_cmp_vld;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_found;
    logic [ADDR_W-1:0]  r_best_mask;
    logic [ADDR_W-1:0]  r_best_dest;
    logic [PORT_W-1:0]  r_best_port;
    logic [IDX_W-1:0]   r_best_idx;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               w_in_acc;
    logic               w_wr_en;
    logic               w_slot_free;
    logic               w_out_load;
    logic               w_take;
    t_route             w_wr_route;
    t_route             w_rd_route;
    logic               w_rd_valid;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    assign w_wr_en = w_in_acc && (i_in_data.op == OP_WRITE)
                     && ({1'b0, i_in_data.entry_index} < (INDEX_W+1)'(EFF_DEPTH));

    assign w_wr_route.dest = i_in_data.entry_dest;
    assign w_wr_route.mask = i_in_data.entry_mask;
    assign w_wr_route.port = sat_port(i_in_data.entry_port);

    ipv4lpm_table #(
        .DEPTH (EFF_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_wr_en),
        .i_wr_idx   (i_in_data.entry_index[IDX_W-1:0]),
        .i_wr_route (w_wr_route),
        .i_wr_valid (i_in_data.entry_valid),
        .i_rd_idx   (r_rd_idx),
        .o_rd_route (w_rd_route),
        .o_rd_valid (w_rd_valid)
    );

    // Compare unit: does this slot match, and beat the best so far?
    always_comb begin
        w_take = r_cmp_vld && w_rd_valid
                 && ((r_addr & w_rd_route.mask) == (w_rd_route.dest & w_rd_route.mask))
                 && (!r_found || (w_rd_route.mask > r_best_mask));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_in_data.op == OP_LOOKUP)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_idx == LAST_IDX) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_cmp_vld && w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_SCAN: ;
            ST_DONE: w_out_load = !r_cmp_vld && w_slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_idx    <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == ST_SCAN);
            if (r_state == ST_SCAN) begin
                r_rd_idx <= (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + 1'b1;
            end
            if (w_in_acc && (i_in_data.op == OP_LOOKUP)) begin
                r_found <= 1'b0;
            end else if (w_take) begin
                r_found <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_rd_idx;
        if (w_in_acc && (i_in_data.op == OP_LOOKUP)) begin
            r_addr <= i_in_data.lookup_addr;
        end
        if (w_take) begin
            r_best_mask <= w_rd_route.mask;
            r_best_dest <= w_rd_route.dest;
            r_best_port <= w_rd_route.port;
            r_best_idx  <= r_cmp_idx;
        end
        if (w_out_load) begin
            r_out.hit         <= r_found;
            r_out.match_index <= r_found ? INDEX_W'(r_best_idx) : '0;
            r_out.match_port  <= r_found ? r_best_port : '0;
            r_out.match_dest  <= r_found ? r_best_dest : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_lookup_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_data.op == OP_LOOKUP)) |=> (r_state == ST_SCAN && r_rd_idx == '0))
        else $error("lookup did not start a scan at slot zero");

    a_write_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_data.op == OP_WRITE)) |=> (r_state == ST_IDLE))
        else $error("write item left the idle state");

    a_cmp_follows_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |=> r_cmp_vld)
        else $error("compare stage missed a table read");

    a_done_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (o_out_valid && r_state == ST_IDLE))
        else $error("finished lookup did not reach the result register");

    a_no_compare_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && $past(r_state) == ST_IDLE) |-> !r_cmp_vld)
        else $error("compare active while idle");

endmodule

// ===== dv/lpm_checker.sv =====
// Checker for the route table: mirrors the table, predicts each lookup and compares results.
`timescale 1ns / 1ps

module lpm_checker
    import ipv4lpm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int REPORT_MAX = 10;

    logic [ADDR_W-1:0] route_dest [TABLE_DEPTH_DEF];
    logic [ADDR_W-1:0] route_mask [TABLE_DEPTH_DEF];
    logic [PORT_W-1:0] route_port [TABLE_DEPTH_DEF];
    logic              route_live [TABLE_DEPTH_DEF];

    t_out_item results_due[$];
    t_out_item want;
    int        fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = results_due.size();

    // Longest mask wins, compared as an unsigned value; strict > keeps the lowest slot on a tie.
    function automatic t_out_item predict_route(input logic [ADDR_W-1:0] addr);
        t_out_item         res;
        logic [ADDR_W-1:0] best_mask;
        res       = '0;
        best_mask = '0;
        for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
            if (route_live[i] && ((addr & route_mask[i]) == (route_dest[i] & route_mask[i]))
                    && (!res.hit || route_mask[i] > best_mask)) begin
                res.hit         = 1'b1;
                res.match_index = INDEX_W'(i);
                res.match_port  = route_port[i];
                res.match_dest  = route_dest[i];
                best_mask       = route_mask[i];
            end
        end
        return res;
    endfunction

    task automatic store_route(input t_in_item it);
        int slot;
        slot = int'(it.entry_index);
        if (slot < TABLE_DEPTH_DEF) begin
            route_dest[slot] = it.entry_dest;
            route_mask[slot] = it.entry_mask;
            route_port[slot] = (int'(it.entry_port) >= NUM_PORTS) ?
                               PORT_W'(NUM_PORTS - 1) : it.entry_port;
            route_live[slot] = it.entry_valid;
        end
    endtask

    initial begin
        fail_count = 0;
        for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
            route_live[i] = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
                route_live[i] = 1'b0;
            end
            results_due.delete();
        end else begin
            // retire the outgoing item first: it can never belong to an item taken this edge
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("%0t: unexpected result: hit=%0b idx=%0d port=%0d dest=%08h",
                                 $realtime, i_out_data.hit, i_out_data.match_index,
                                 i_out_data.match_port, i_out_data.match_dest);
                    end
                end else begin
                    want = results_due.pop_front();
                    if (i_out_data.hit !== want.hit
                            || i_out_data.match_index !== want.match_index
                            || i_out_data.match_port !== want.match_port
                            || i_out_data.match_dest !== want.match_dest) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX) begin
                            $display("%0t: hit/idx/port/dest exp %0b/%0d/%0d/%08h got %0b/%0d/%0d/%08h",
                                     $realtime, want.hit, want.match_index, want.match_port,
                                     want.match_dest, i_out_data.hit, i_out_data.match_index,
                                     i_out_data.match_port, i_out_data.match_dest);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.op == OP_LOOKUP) begin
                    results_due.push_back(predict_route(i_in_data.lookup_addr));
                end else begin
                    store_route(i_in_data);
                end
            end
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top: clock, reset, item stimulus with random idling, and the final verdict.
`timescale 1ns / 1ps

module tb_top
    import ipv4lpm_pkg::*;
();

    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 1_000_000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;
    int        fail_count;
    int        pending;
    int        cycles    = 0;
    logic      hold_req  = 1'b0;
    int        sender_calm = 0;

    // what the stimulus has written so far, used to aim lookups at live prefixes and to extend them in new writes
    logic [ADDR_W-1:0] aim_dest [TABLE_DEPTH_DEF];
    logic [ADDR_W-1:0] aim_mask [TABLE_DEPTH_DEF];
    logic              aim_set  [TABLE_DEPTH_DEF];

    ipv4_longest_prefix_match u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    lpm_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_in_item write_item(input logic [INDEX_W-1:0] slot,
                                            input logic [ADDR_W-1:0] dest,
                                            input logic [ADDR_W-1:0] mask,
                                            input logic [PORT_W-1:0] port,
                                            input logic live);
        t_in_item it;
        it.op          = OP_WRITE;
        it.entry_index = slot;
        it.entry_dest  = dest;
        it.entry_mask  = mask;
        it.entry_port  = port;
        it.entry_valid = live;
        it.lookup_addr = $urandom();
        return it;
    endfunction

    function automatic t_in_item lookup_item(input logic [ADDR_W-1:0] addr);
        t_in_item it;
        it.op          = OP_LOOKUP;
        it.entry_index = INDEX_W'($urandom_range(15, 0));
        it.entry_dest  = $urandom();
        it.entry_mask  = $urandom();
        it.entry_port  = PORT_W'($urandom_range(3, 0));
        it.entry_valid = 1'(($urandom_range(1, 0)));
        it.lookup_addr = addr;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        int roll;
        gap = 0;
        if (sender_calm > 0) begin
            sender_calm--;
        end else begin
            roll = $urandom_range(99, 0);
            if (roll < 2) begin
                sender_calm = $urandom_range(80, 20);
            end else if (roll < 50) begin
                gap = 0;
            end else if (roll < 88) begin
                gap = $urandom_range(3, 1);
            end else if (roll < 98) begin
                gap = $urandom_range(12, 4);
            end else begin
                gap = $urandom_range(80, 20);
            end
        end
        if (it.op == OP_WRITE && int'(it.entry_index) < TABLE_DEPTH_DEF) begin
            aim_dest[it.entry_index] = it.entry_dest;
            aim_mask[it.entry_index] = it.entry_mask;
            aim_set[it.entry_index]  = it.entry_valid;
        end
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
    endtask

    // receiver: random stalls, calm stretches, and one long hold-off on request
    initial begin
        int stall_left;
        int calm_left;
        int hold_left;
        int roll;
        stall_left = 0;
        calm_left  = 0;
        hold_left  = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else begin
                    roll = $urandom_range(99, 0);
                    if (roll < 3) begin
                        calm_left = $urandom_range(200, 50);
                    end else if (roll < 60) begin
                        stall_left = 0;
                    end else if (roll < 92) begin
                        stall_left = $urandom_range(4, 1);
                    end else begin
                        stall_left = $urandom_range(60, 10);
                    end
                end
            end
        end
    end

    initial begin
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] addr;
        int                roll;
        int                plen;
        int                s;
        for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
            aim_set[i]  = 1'b0;
            aim_dest[i] = '0;
            aim_mask[i] = '0;
        end
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // empty table misses at both address extremes
        send_item(lookup_item(32'h0000_0000));
        send_item(lookup_item(32'hFFFF_FFFF));
        // default route, then nested prefixes with a tie on /24
        send_item(write_item(4'd15, 32'h0000_0000, 32'h0000_0000, 2'd3, 1'b1));
        send_item(lookup_item(32'h0A00_0001));
        send_item(write_item(4'd0, 32'h0A00_0000, 32'hFF00_0000, 2'd1, 1'b1));
        send_item(write_item(4'd1, 32'h0A01_0000, 32'hFFFF_0000, 2'd2, 1'b1));
        send_item(write_item(4'd2, 32'h0A01_0100, 32'hFFFF_FF00, 2'd0, 1'b1));
        send_item(write_item(4'd3, 32'h0A01_0101, 32'hFFFF_FFFF, 2'd3, 1'b1));
        send_item(write_item(4'd4, 32'h0A01_01FF, 32'hFFFF_FF00, 2'd2, 1'b1));
        send_item(lookup_item(32'h0A01_0101));
        send_item(lookup_item(32'h0A01_0102));
        send_item(lookup_item(32'h0A02_0304));
        send_item(lookup_item(32'h0B00_0000));
        // removing the host route falls back to the /24
        send_item(write_item(4'd3, 32'h0A01_0101, 32'hFFFF_FFFF, 2'd3, 1'b0));
        send_item(lookup_item(32'h0A01_0101));
        send_item(write_item(4'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd1, 1'b1));
        send_item(lookup_item(32'hFFFF_FFFF));
        // non-contiguous mask is ranked by its plain value
        send_item(write_item(4'd6, 32'hA0B0_C0D0, 32'hF0F0_F0F0, 2'd0, 1'b1));
        send_item(lookup_item(32'hA5B5_C5D5));
        send_item(write_item(4'd15, 32'h0000_0000, 32'h0000_0000, 2'd3, 1'b0));
        send_item(lookup_item(32'h0B00_0000));
        send_item(lookup_item(32'h0000_0000));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT) begin
                hold_req = 1'b1;
            end
            roll = $urandom_range(99, 0);
            if (roll < 30 && !(n >= HOLD_AT && n < HOLD_AT + 50)) begin
                roll = $urandom_range(99, 0);
                if (roll < 5) begin
                    mask = '0;
                end else if (roll < 85) begin
                    plen = $urandom_range(32, 1);
                    mask = 32'hFFFF_FFFF << (32 - plen);
                end else begin
                    mask = $urandom();
                end
                s = $urandom_range(15, 0);
                if ($urandom_range(1, 0) == 1 && aim_set[s]) begin
                    // extend an existing prefix so lookups see nested candidates
                    dest = (aim_dest[s] & aim_mask[s]) | ($urandom() & ~aim_mask[s]);
                end else begin
                    dest = $urandom();
                end
                send_item(write_item(INDEX_W'($urandom_range(15, 0)), dest, mask,
                                     PORT_W'($urandom_range(3, 0)),
                                     ($urandom_range(99, 0) < 85)));
            end else begin
                roll = $urandom_range(99, 0);
                s    = $urandom_range(15, 0);
                if (roll < 65 && aim_set[s]) begin
                    addr = (aim_dest[s] & aim_mask[s]) | ($urandom() & ~aim_mask[s]);
                end else if (roll < 80 && aim_set[s]) begin
                    addr = aim_dest[s] ^ (32'h1 << $urandom_range(31, 0));
                end else if (roll < 97) begin
                    addr = $urandom();
                end else begin
                    addr = ($urandom_range(1, 0) == 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                end
                send_item(lookup_item(addr));
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
